[hdl/svx_pkg.sv]
package svx_pkg;

    localparam int SAMPLE_W        = 16;
    localparam int PROB_W          = 16;
    localparam int INDEX_W         = 6;
    localparam int LEN_W           = 7;
    localparam int SUM_W           = 23;
    localparam int EXP_W           = 17;
    localparam int EXP_TABLE_DEPTH = 256;
    localparam int EXP_IDX_W       = $clog2(EXP_TABLE_DEPTH);
    localparam int FRAC_BITS       = 23;
    localparam int PROD_W          = 32;
    localparam int SHIFT_LIMIT     = 18;
    localparam logic [15:0] LOG2E_Q15 = 16'd47274;
    localparam logic [63:0] LN2_Q30   = 64'd744261118;
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
    localparam logic signed [SAMPLE_W-1:0] MOST_NEGATIVE = {1'b1, {(SAMPLE_W-1){1'b0}}};

    typedef logic [EXP_TABLE_DEPTH-1:0][EXP_W-1:0] exp_tab_t;

    // Table of 2^(-i/depth) in Q1.16, from the series of exp(-i*ln2/depth) up to the 12th power.
    function automatic exp_tab_t build_exp_table();
        exp_tab_t    tab;
        logic [63:0] a;
        logic [63:0] term;
        logic [63:0] acc;
        for (int i = 0; i < EXP_TABLE_DEPTH; i++)
        begin
            a    = (64'(i) * LN2_Q30) / 64'(EXP_TABLE_DEPTH);
            term = 64'd1 << 30;
            acc  = term;
            for (int n = 1; n <= 12; n++)
            begin
                term = ((term * a) >> 30) / 64'(n);
                if ((n % 2) == 1)
                    acc = acc - term;
                else
                    acc = acc + term;
            end
            tab[i] = EXP_W'((acc + 64'd8192) >> 14);
        end
        return tab;
    endfunction

    localparam exp_tab_t EXP_TABLE = build_exp_table();

endpackage

[hdl/svx_if.sv]
interface svx_sample_if;
    import svx_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_value;

    modport source (output valid, output sample_value, input ready);
    modport sink (input valid, input sample_value, output ready);
endinterface

interface svx_result_if;
    import svx_pkg::*;
    logic               valid;
    logic               ready;
    logic [PROB_W-1:0]  probability;
    logic [INDEX_W-1:0] element_index;
    logic               last_flag;

    modport source (output valid, output probability, output element_index,
                    output last_flag, input ready);
    modport sink (input valid, input probability, input element_index,
                  input last_flag, output ready);
endinterface

[hdl/softmax_vector_top.sv]
// Softmax over a vector of signed Q8.8 samples.
// The samples channel takes one element per beat; the results channel gives one
// unsigned Q0.16 probability per element, with its position and a flag on the last
// beat of the vector. The vector length comes from the register at byte address 0
// of the APB port (reset value 64; zero and values above MAX_LENGTH are clamped).
// The intake stores samples into one of two banks while tracking the maximum, and
// hands a finished vector to the engine through a two-deep queue, so a second
// vector can be loaded while the first one is worked on. The intake stalls only
// when both banks hold vectors not yet fully delivered.
// The engine makes two passes over the stored vector through one shared exp unit
// (memory read, 16x16 multiply, table lookup and rounding shift): the first pass
// adds the exp values up to build the sum, and the second recomputes each one and
// feeds it to the 16-step bit-serial divider that forms e * 65536 / sum, rounded
// and saturated at 65535. A stalled receiver holds the output register and
// freezes the engine; the intake keeps taking samples meanwhile. Reset empties
// the queue, the banks and the output register and sets the length back to 64.
module softmax_vector_top
    import svx_pkg::*;
#(
    parameter int MAX_LENGTH = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    svx_sample_if.sink   samples,
    svx_result_if.source results,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = $clog2(MAX_LENGTH);
    localparam int CW = $clog2(MAX_LENGTH + 1);
    localparam logic REG_VECTOR_LENGTH = 1'b0;

    typedef struct packed {
        logic                       bank;
        logic [CW-1:0]              count;
        logic signed [SAMPLE_W-1:0] vmax;
    } job_t;

    typedef struct packed {
        logic                       en;
        logic [AW:0]                addr;
        logic signed [SAMPLE_W-1:0] data;
    } wr_t;

    logic [LEN_W-1:0] length_reg;
    logic             reg_write;
    logic             job_push, job_pop, job_avail, job_done;
    job_t             push_job, head_job;
    wr_t              store_wr;

    // Only bit 2 of the address selects a register; there is one register.
    assign pready    = 1'b1;
    assign reg_write = psel && penable && pwrite && (paddr[2] == REG_VECTOR_LENGTH);
    assign prdata    = (paddr[2] == REG_VECTOR_LENGTH) ? 32'(length_reg) : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            length_reg <= LEN_W'(64);
        else if (reg_write)
            length_reg <= pwdata[LEN_W-1:0];
    end

    svx_intake #(
        .MAX_LENGTH (MAX_LENGTH),
        .job_t      (job_t),
        .wr_t       (wr_t)
    ) u_intake (
        .clk           (clk),
        .rst_n         (rst_n),
        .samples       (samples),
        .vector_length (length_reg),
        .job_done      (job_done),
        .job_push      (job_push),
        .job           (push_job),
        .store_wr      (store_wr)
    );

    svx_job_fifo #(
        .job_t (job_t)
    ) u_job_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (job_push),
        .push_job (push_job),
        .pop      (job_pop),
        .avail    (job_avail),
        .head_job (head_job)
    );

    svx_engine #(
        .MAX_LENGTH (MAX_LENGTH),
        .job_t      (job_t),
        .wr_t       (wr_t)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_avail (job_avail),
        .job       (head_job),
        .job_pop   (job_pop),
        .store_wr  (store_wr),
        .job_done  (job_done),
        .results   (results)
    );

endmodule

[hdl/svx_intake.sv]
module svx_intake
    import svx_pkg::*;
#(
    parameter int  MAX_LENGTH = 64,
    parameter type job_t,
    parameter type wr_t
)
(
    input  logic              clk,
    input  logic              rst_n,
    svx_sample_if.sink        samples,
    input  logic [LEN_W-1:0]  vector_length,
    input  logic              job_done,
    output logic              job_push,
    output job_t              job,
    output wr_t               store_wr
);

    localparam int AW = $clog2(MAX_LENGTH);
    localparam int CW = $clog2(MAX_LENGTH + 1);
    localparam int LW = (CW > LEN_W) ? CW : LEN_W;

    logic [CW-1:0]              count_reg, count_next;
    logic signed [SAMPLE_W-1:0] max_reg, max_next;
    logic                       bank_reg, bank_next;
    logic [1:0]                 jobs_reg, jobs_next;

    logic [LW-1:0]              len_ext, eff_len;
    logic [CW-1:0]              cnt_inc;
    logic signed [SAMPLE_W-1:0] new_max;
    logic                       accept, complete;

    always_comb
    begin
        len_ext = LW'(vector_length);
        if (len_ext == '0)
            eff_len = LW'(1);
        else if (len_ext > LW'(MAX_LENGTH))
            eff_len = LW'(MAX_LENGTH);
        else
            eff_len = len_ext;
    end

    assign samples.ready = (jobs_reg < 2'd2);
    assign accept        = samples.valid & samples.ready;
    assign cnt_inc       = count_reg + CW'(1);
    assign new_max       = (samples.sample_value > max_reg) ? samples.sample_value : max_reg;
    assign complete      = LW'(cnt_inc) >= eff_len;

    assign store_wr.en   = accept;
    assign store_wr.addr = {bank_reg, count_reg[AW-1:0]};
    assign store_wr.data = samples.sample_value;

    assign job_push  = accept & complete;
    assign job.bank  = bank_reg;
    assign job.count = cnt_inc;
    assign job.vmax  = new_max;

    always_comb
    begin
        count_next = count_reg;
        max_next   = max_reg;
        bank_next  = bank_reg;
        if (accept)
        begin
            if (complete)
            begin
                count_next = '0;
                max_next   = MOST_NEGATIVE;
                bank_next  = ~bank_reg;
            end
            else
            begin
                count_next = cnt_inc;
                max_next   = new_max;
            end
        end
        jobs_next = jobs_reg + 2'(job_push) - 2'(job_done);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            max_reg   <= MOST_NEGATIVE;
            bank_reg  <= 1'b0;
            jobs_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            max_reg   <= max_next;
            bank_reg  <= bank_next;
            jobs_reg  <= jobs_next;
        end
    end

endmodule

[hdl/svx_job_fifo.sv]
module svx_job_fifo
    import svx_pkg::*;
#(
    parameter type job_t
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output logic avail,
    output job_t head_job
);

    job_t       slot_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] fill_reg;

    assign avail    = (fill_reg != 2'd0);
    assign head_job = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            fill_reg <= fill_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

[hdl/svx_engine.sv]
module svx_engine
    import svx_pkg::*;
#(
    parameter int  MAX_LENGTH = 64,
    parameter type job_t,
    parameter type wr_t
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          job_avail,
    input  job_t          job,
    output logic          job_pop,
    input  wr_t           store_wr,
    output logic          job_done,
    svx_result_if.source  results
);

    localparam int AW = $clog2(MAX_LENGTH);
    localparam int CW = $clog2(MAX_LENGTH + 1);
    localparam int DW = EXP_W + 16;
    localparam int SW = SUM_W + 16;

    typedef enum logic [2:0] {
        ST_IDLE, ST_READ, ST_MUL, ST_EXP, ST_ACC, ST_DIVINIT, ST_DIV, ST_OUT
    } state_t;

    logic signed [SAMPLE_W-1:0] store_mem [2**(AW+1)];
    logic signed [SAMPLE_W-1:0] rdata_reg;

    state_t                     state_reg;
    logic                       pass2_reg;
    logic                       bank_reg;
    logic [CW-1:0]              n_reg;
    logic signed [SAMPLE_W-1:0] max_reg;
    logic [AW-1:0]              i_reg;
    logic [PROD_W-1:0]          u_reg;
    logic [EXP_W-1:0]           e_reg;
    logic [SUM_W-1:0]           sum_reg;
    logic [SUM_W-1:0]           rem_reg;
    logic [15:0]                low_reg;
    logic [3:0]                 step_reg;
    logic                       ovalid_reg;
    logic [PROB_W-1:0]          prob_reg;
    logic [INDEX_W-1:0]         index_reg;
    logic                       olast_reg;
    logic                       done_reg;

    logic [SAMPLE_W-1:0]        gap;
    logic [PROD_W-1:0]          prod;
    logic [PROD_W-FRAC_BITS-1:0] shift_k;
    logic [EXP_W-1:0]           tab_val;
    logic [EXP_W:0]             rounded;
    logic [EXP_W-1:0]           e_val;
    logic [SUM_W:0]             sum_wide;
    logic [DW:0]                dividend;
    logic                       saturate;
    logic [SUM_W:0]             trial;
    logic                       trial_ge;
    logic                       is_last;
    logic                       out_free;

    assign gap      = SAMPLE_W'(max_reg - rdata_reg);
    assign prod     = PROD_W'(gap) * PROD_W'(LOG2E_Q15);
    assign shift_k  = u_reg[PROD_W-1:FRAC_BITS];
    assign tab_val  = EXP_TABLE[u_reg[FRAC_BITS-1 -: EXP_IDX_W]];
    assign is_last  = (CW'(i_reg) + CW'(1)) == n_reg;
    assign out_free = !ovalid_reg || results.ready;
    assign sum_wide = {1'b0, sum_reg} + (SUM_W+1)'(e_reg);
    assign dividend = ((DW+1)'(e_reg) << 16) + (DW+1)'(sum_reg >> 1);
    assign saturate = SW'(dividend) >= {sum_reg, 16'd0};
    assign trial    = {rem_reg, low_reg[15]};
    assign trial_ge = trial >= {1'b0, sum_reg};
    assign job_pop  = (state_reg == ST_IDLE) && job_avail;

    // Rounded right shift of the table value; shifts past the table width give zero.
    always_comb
    begin
        rounded = '0;
        e_val   = '0;
        if (shift_k < (PROD_W-FRAC_BITS)'(SHIFT_LIMIT))
        begin
            if (shift_k == '0)
                rounded = {1'b0, tab_val};
            else
                rounded = {1'b0, tab_val} + ((EXP_W+1)'(1) << (shift_k - 1'b1));
            e_val = EXP_W'(rounded >> shift_k);
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_wr.en)
            store_mem[store_wr.addr] <= store_wr.data;
        rdata_reg <= store_mem[{bank_reg, i_reg}];
    end

    always_ff @(posedge clk)
    begin
        u_reg <= prod;
        e_reg <= e_val;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            pass2_reg  <= 1'b0;
            bank_reg   <= 1'b0;
            n_reg      <= '0;
            max_reg    <= MOST_NEGATIVE;
            i_reg      <= '0;
            sum_reg    <= '0;
            rem_reg    <= '0;
            low_reg    <= '0;
            step_reg   <= '0;
            ovalid_reg <= 1'b0;
            prob_reg   <= '0;
            index_reg  <= '0;
            olast_reg  <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (results.ready)
                ovalid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (job_avail)
                    begin
                        bank_reg  <= job.bank;
                        n_reg     <= job.count;
                        max_reg   <= job.vmax;
                        i_reg     <= '0;
                        sum_reg   <= '0;
                        pass2_reg <= 1'b0;
                        state_reg <= ST_READ;
                    end
                end
                ST_READ:
                    state_reg <= ST_MUL;
                ST_MUL:
                    state_reg <= ST_EXP;
                ST_EXP:
                    state_reg <= pass2_reg ? ST_DIVINIT : ST_ACC;
                ST_ACC:
                begin
                    if (sum_wide > {1'b0, SUM_MAX})
                        sum_reg <= SUM_MAX;
                    else
                        sum_reg <= sum_wide[SUM_W-1:0];
                    if (is_last)
                    begin
                        pass2_reg <= 1'b1;
                        i_reg     <= '0;
                        if (sum_wide == '0)
                            sum_reg <= SUM_W'(1);
                    end
                    else
                        i_reg <= i_reg + 1'b1;
                    state_reg <= ST_READ;
                end
                ST_DIVINIT:
                begin
                    if (saturate)
                    begin
                        low_reg   <= 16'hFFFF;
                        state_reg <= ST_OUT;
                    end
                    else
                    begin
                        rem_reg   <= SUM_W'(dividend >> 16);
                        low_reg   <= dividend[15:0];
                        step_reg  <= '0;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    rem_reg  <= trial_ge ? SUM_W'(trial - {1'b0, sum_reg}) : SUM_W'(trial);
                    low_reg  <= {low_reg[14:0], trial_ge};
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == 4'd15)
                        state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (out_free)
                    begin
                        ovalid_reg <= 1'b1;
                        prob_reg   <= low_reg;
                        index_reg  <= INDEX_W'(i_reg);
                        olast_reg  <= is_last;
                        if (is_last)
                        begin
                            done_reg  <= 1'b1;
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            i_reg     <= i_reg + 1'b1;
                            state_reg <= ST_READ;
                        end
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    assign job_done              = done_reg;
    assign results.valid         = ovalid_reg;
    assign results.probability   = prob_reg;
    assign results.element_index = index_reg;
    assign results.last_flag     = olast_reg;

endmodule

[tb/sv/softmax_result_checker.sv]
module softmax_result_checker
    import svx_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    svx_sample_if        samples,
    svx_result_if        results,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    input  logic         pready,
    output int           mismatches,
    output int           outstanding,
    output int           beats_checked
);

    localparam int VEC_MAX = 64;

    typedef struct packed {
        logic [PROB_W-1:0]  probability;
        logic [INDEX_W-1:0] element_index;
        logic               last_flag;
    } softmax_beat_t;

    logic [16:0]               pow2_frac [EXP_TABLE_DEPTH];
    logic [LEN_W-1:0]          length_reg;
    logic signed [SAMPLE_W-1:0] vec_elems [VEC_MAX];
    int                        vec_fill;
    logic signed [SAMPLE_W-1:0] vec_max;
    softmax_beat_t             expected_beats [$];

    // One entry of 2^(-i/depth) in Q1.16 via the series of exp(-i*ln2/depth) up to the 12th power.
    function automatic logic [16:0] pow2_entry(int i);
        logic [63:0] arg;
        logic [63:0] t;
        logic [63:0] total;
        arg   = (64'(i) * 64'd744261118) / 64'(EXP_TABLE_DEPTH);
        t     = 64'd1 << 30;
        total = t;
        for (int n = 1; n <= 12; n++)
        begin
            t = ((t * arg) >> 30) / 64'(n);
            total = (n % 2 == 1) ? total - t : total + t;
        end
        return 17'((total + 64'd8192) >> 14);
    endfunction

    function automatic logic [31:0] exp_of_gap(logic [15:0] gap);
        logic [63:0] scaled;
        logic [63:0] shift;
        logic [7:0]  idx;
        logic [63:0] rounded;
        scaled = 64'(gap) * 64'd47274;
        shift  = scaled >> 23;
        idx    = scaled[22:15];
        if (shift >= 32)
            return 32'd0;
        rounded = 64'(pow2_frac[idx]) + ((shift != 0) ? (64'd1 << (shift - 1)) : 64'd0);
        return 32'(rounded >> shift);
    endfunction

    // Closes the current vector and queues one probability beat per element.
    task automatic emit_vector();
        logic [63:0]   sum;
        logic [63:0]   e;
        logic [63:0]   p;
        softmax_beat_t b;
        sum = 0;
        for (int i = 0; i < vec_fill; i++)
        begin
            sum += exp_of_gap(16'(vec_max - vec_elems[i]));
            if (sum > 64'd8388607)
                sum = 64'd8388607;
        end
        if (sum == 0)
            sum = 1;
        for (int i = 0; i < vec_fill; i++)
        begin
            e = exp_of_gap(16'(vec_max - vec_elems[i]));
            p = ((e << 16) + (sum >> 1)) / sum;
            b.probability   = (p > 64'd65535) ? 16'hFFFF : p[15:0];
            b.element_index = INDEX_W'(i);
            b.last_flag     = (i + 1 == vec_fill);
            expected_beats.push_back(b);
        end
        vec_fill = 0;
        vec_max  = MOST_NEGATIVE;
    endtask

    initial
    begin
        for (int i = 0; i < EXP_TABLE_DEPTH; i++)
            pow2_frac[i] = pow2_entry(i);
        mismatches    = 0;
        beats_checked = 0;
    end

    assign outstanding = expected_beats.size();

    always @(posedge clk or negedge rst_n)
    begin
        softmax_beat_t want;
        int            eff_len;
        if (!rst_n)
        begin
            length_reg = 7'd64;
            vec_fill   = 0;
            vec_max    = MOST_NEGATIVE;
            expected_beats.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr[2] == 1'b0)
                length_reg = pwdata[LEN_W-1:0];

            if (samples.valid && samples.ready)
            begin
                eff_len = (length_reg == 0) ? 1 : (length_reg > VEC_MAX) ? VEC_MAX : length_reg;
                if (vec_fill >= VEC_MAX)
                    vec_fill = VEC_MAX - 1;
                vec_elems[vec_fill] = samples.sample_value;
                if (samples.sample_value > vec_max)
                    vec_max = samples.sample_value;
                vec_fill++;
                if (vec_fill >= eff_len)
                    emit_vector();
            end

            if (results.valid && results.ready)
            begin
                beats_checked++;
                if (expected_beats.size() == 0)
                begin
                    $error("unexpected result beat: probability %0d index %0d last %0d",
                           results.probability, results.element_index, results.last_flag);
                    mismatches++;
                end
                else
                begin
                    want = expected_beats.pop_front();
                    if (results.probability !== want.probability)
                    begin
                        $error("probability: expected %0d, got %0d",
                               want.probability, results.probability);
                        mismatches++;
                    end
                    if (results.element_index !== want.element_index)
                    begin
                        $error("element_index: expected %0d, got %0d",
                               want.element_index, results.element_index);
                        mismatches++;
                    end
                    if (results.last_flag !== want.last_flag)
                    begin
                        $error("last_flag: expected %0d, got %0d",
                               want.last_flag, results.last_flag);
                        mismatches++;
                    end
                end
            end
        end
    end

endmodule

[tb/sv/testbench.sv]
// Stimulus and verdict for the softmax block. All prediction and comparison is
// done by softmax_result_checker, which watches both channels and the register port.
module testbench;
    import svx_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    svx_sample_if samples_ch ();
    svx_result_if results_ch ();

    int mismatches;
    int outstanding;
    int beats_checked;
    int samples_sent;

    // Receiver shaping: a long hold-off counter, and a flag that turns idling off.
    int hold_cycles;
    bit calm;
    int stall_left;

    softmax_vector_top uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples_ch),
        .results (results_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    softmax_result_checker chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .samples       (samples_ch),
        .results       (results_ch),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .mismatches    (mismatches),
        .outstanding   (outstanding),
        .beats_checked (beats_checked)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // The receiver lowers ready in random bursts, unless the run is in its calm
    // stretch. A requested hold-off overrides everything.
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles--;
            results_ch.ready = 1'b0;
        end
        else if (calm)
        begin
            results_ch.ready = 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            results_ch.ready = 1'b0;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(1, 16) - 1;
            results_ch.ready = 1'b0;
        end
        else
        begin
            results_ch.ready = 1'b1;
        end
    end

    // Register write: setup cycle, then access cycle; the write lands at the
    // rising edge of the access cycle.
    task automatic write_length(input logic [31:0] value);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = 3'd0;
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // One sample beat, optionally preceded by a random sender gap. Called at a
    // falling edge; returns at the falling edge after the beat was taken.
    task automatic send_sample(input logic signed [15:0] value);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            samples_ch.valid = 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clk);
        end
        samples_ch.valid        = 1'b1;
        samples_ch.sample_value = value;
        do
            @(posedge clk);
        while (!samples_ch.ready);
        samples_sent++;
        @(negedge clk);
        samples_ch.valid = 1'b0;
    endtask

    // Sender pause: everything predicted must come back, then the engine gets
    // time to settle in case a partial vector is still being loaded.
    task automatic drain_results();
        samples_ch.valid = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (60) @(negedge clk);
    endtask

    // Elements clustered around a base give nontrivial probabilities; full
    // random values exercise every bit and the deep-underflow exp path.
    function automatic logic signed [15:0] pick_sample(logic signed [15:0] base);
        if ($urandom_range(0, 3) == 0)
            return 16'($urandom);
        return base + 16'($urandom_range(0, 1535)) - 16'sd768;
    endfunction

    task automatic send_vectors(input int len, input int count);
        logic signed [15:0] base;
        for (int v = 0; v < count; v++)
        begin
            base = 16'($urandom);
            for (int i = 0; i < len; i++)
                send_sample(pick_sample(base));
        end
    endtask

    initial
    begin
        int lens [8] = '{3, 6, 2, 8, 1, 16, 4, 7};
        rst_n                   = 1'b0;
        psel                    = 1'b0;
        penable                 = 1'b0;
        pwrite                  = 1'b0;
        paddr                   = 3'd0;
        pwdata                  = 32'd0;
        samples_ch.valid        = 1'b0;
        samples_ch.sample_value = '0;
        results_ch.ready        = 1'b0;
        hold_cycles             = 0;
        calm                    = 1'b0;
        stall_left              = 0;
        samples_sent            = 0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        repeat (5) @(negedge clk);

        // Single-element vectors at both extremes: each must saturate to 65535.
        write_length(32'd1);
        send_sample(16'sh7FFF);
        send_sample(-16'sh8000);
        drain_results();

        // Length zero clamps to one.
        write_length(32'd0);
        send_sample(16'sd0);
        drain_results();

        // Widest spread: the minimum's exp underflows to zero.
        write_length(32'd2);
        send_sample(16'sh7FFF);
        send_sample(-16'sh8000);
        drain_results();

        // Equal elements split evenly.
        write_length(32'd4);
        for (int i = 0; i < 4; i++)
            send_sample(16'sh0100);
        drain_results();

        // The length shrinks under a partial vector: the next sample completes it
        // with all four elements received so far.
        write_length(32'd8);
        send_sample(16'sh0080);
        send_sample(-16'sh0200);
        send_sample(16'sh0300);
        drain_results();
        write_length(32'd2);
        send_sample(16'sh0000);
        drain_results();

        // Length above the maximum clamps to 64: one full-size vector.
        write_length(32'd127);
        send_vectors(64, 1);
        drain_results();

        // The receiver holds off long enough that both banks fill and the
        // intake has to stall while the sender keeps offering beats.
        write_length(32'd5);
        hold_cycles = 600;
        send_vectors(5, 3);
        drain_results();

        for (int p = 0; p < 8; p++)
        begin
            if (p >= 6)
                calm = 1'b1;
            write_length(32'(lens[p]));
            send_vectors(lens[p], 1);
            drain_results();
        end

        // Two short vectors back to back with no idling on either side, to finish.
        write_length(32'd10);
        send_vectors(10, 2);

        while (outstanding != 0)
            @(negedge clk);
        repeat (300) @(negedge clk);

        if (outstanding != 0)
            $error("%0d expected result beats never arrived", outstanding);

        $display("Run covered %0d samples and %0d result beats, vector lengths 1 to 64,",
                 samples_sent, beats_checked);
        $display("length clamping, a mid-vector length change and a long receiver stall.");
        if (mismatches == 0 && outstanding == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #6000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

[filelist.f]
hdl/svx_pkg.sv
hdl/svx_if.sv
hdl/svx_intake.sv
hdl/svx_job_fifo.sv
hdl/svx_engine.sv
hdl/softmax_vector_top.sv
tb/sv/softmax_result_checker.sv
tb/sv/testbench.sv
